// ===== sv/sxg_pkg.sv =====
// ---------------------------------------------------------------------------
// sxg_pkg
// Shared types, codes and the mix function of the salted xorshift generator.
// ---------------------------------------------------------------------------
package sxg_pkg;

  localparam int unsigned STATE_W  = 64;
  localparam int unsigned LEN_W    = 9;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // request lengths are also held to this many words
  localparam int unsigned MAX_RESULTS     = 32;
  localparam int unsigned MAX_OUT_BYTES_D = 256;

  localparam int unsigned SHIFT_A = 13;
  localparam int unsigned SHIFT_B = 7;
  localparam int unsigned SHIFT_C = 17;

  localparam logic [STATE_W-1:0] SEED_RESET  = 64'hF1B2_7D94_E3AC_5860;
  localparam logic [STATE_W-1:0] KEY_RESET   = 64'h8EB5_3B1E_4C3D_9A7F;
  localparam logic [STATE_W-1:0] TOKEN_RESET = 64'hC9A4_F60E_8B1D_2753;

  // operation codes
  localparam logic [1:0] OP_SALT  = 2'd0;
  localparam logic [1:0] OP_TOKEN = 2'd1;
  localparam logic [1:0] OP_KEY   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOKEN = 2'd2;

  // one generation request handed from front to back
  typedef struct packed {
    logic [STATE_W-1:0] start_state;
    logic [STATE_W-1:0] mix_const;
    logic [LEN_W-1:0]   length;
  } gen_cmd_t;

  function automatic logic [STATE_W-1:0] mix_step(input logic [STATE_W-1:0] s_in,
                                                   input logic [STATE_W-1:0] k);
    logic [STATE_W-1:0] s;
    s = s_in ^ k;
    s = s ^ (s << SHIFT_A);
    s = s ^ (s >> SHIFT_B);
    s = s ^ (s << SHIFT_C);
    return s;
  endfunction

endpackage

// ===== sv/sxg_front.sv =====
// ---------------------------------------------------------------------------
// sxg_front
// Holds the configuration and the salted state, absorbs salt bytes and turns
// generation requests into commands for the back end.
// ---------------------------------------------------------------------------
module sxg_front #(
  parameter int unsigned MAX_OUT_BYTES = sxg_pkg::MAX_OUT_BYTES_D
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [sxg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sxg_pkg::STATE_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      op,
  input  logic [7:0]                      salt_byte,
  input  logic [sxg_pkg::LEN_W-1:0]       out_length,
  output logic                            cmd_push,
  output sxg_pkg::gen_cmd_t               cmd,
  input  logic                            cmd_full
);

  localparam int unsigned BYTE_CAP   = 8 * sxg_pkg::MAX_RESULTS;
  localparam int unsigned LIMIT_I    = (MAX_OUT_BYTES < BYTE_CAP) ? MAX_OUT_BYTES : BYTE_CAP;
  localparam logic [sxg_pkg::LEN_W-1:0] LEN_LIMIT = sxg_pkg::LEN_W'(LIMIT_I);

  logic [sxg_pkg::STATE_W-1:0] seed_value;
  logic [sxg_pkg::STATE_W-1:0] key_constant;
  logic [sxg_pkg::STATE_W-1:0] token_constant;
  logic [sxg_pkg::STATE_W-1:0] running_state;
  logic [2:0]                  salt_lane;

  logic                        accept;
  logic                        is_req;
  logic [sxg_pkg::LEN_W-1:0]   len_clamped;
  logic [sxg_pkg::STATE_W-1:0] salted;

  assign in_ready = !cmd_full;
  assign accept   = in_valid && in_ready;
  assign is_req   = (op == sxg_pkg::OP_TOKEN) || (op == sxg_pkg::OP_KEY);

  assign len_clamped = (out_length > LEN_LIMIT) ? LEN_LIMIT : out_length;
  assign salted = running_state ^ (sxg_pkg::STATE_W'(salt_byte) << {salt_lane, 3'b000});

  always_comb begin
    cmd.length = len_clamped;
    if (op == sxg_pkg::OP_TOKEN) begin
      cmd.start_state = running_state;
      cmd.mix_const   = token_constant;
    end else begin
      cmd.start_state = seed_value;
      cmd.mix_const   = key_constant;
    end
  end

  // zero length requests only restart the state
  assign cmd_push = accept && is_req && (len_clamped != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value     <= sxg_pkg::SEED_RESET;
      key_constant   <= sxg_pkg::KEY_RESET;
      token_constant <= sxg_pkg::TOKEN_RESET;
      running_state  <= sxg_pkg::SEED_RESET;
      salt_lane      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        sxg_pkg::REG_SEED: begin
          seed_value    <= cfg_data;
          running_state <= cfg_data;
          salt_lane     <= '0;
        end
        sxg_pkg::REG_KEY:   key_constant   <= cfg_data;
        sxg_pkg::REG_TOKEN: token_constant <= cfg_data;
        default: ;
      endcase
    end else if (accept) begin
      if (op == sxg_pkg::OP_SALT) begin
        running_state <= sxg_pkg::mix_step(salted, token_constant);
        salt_lane     <= salt_lane + 3'd1;
      end else if (is_req) begin
        running_state <= seed_value;
        salt_lane     <= '0;
      end
    end
  end

endmodule

// ===== sv/sxg_queue.sv =====
// ---------------------------------------------------------------------------
// sxg_queue
// Two-entry command queue between front and back end.
// ---------------------------------------------------------------------------
module sxg_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sxg_pkg::gen_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output sxg_pkg::gen_cmd_t head_cmd,
  output logic              empty
);

  sxg_pkg::gen_cmd_t entries [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule

// ===== sv/sxg_back.sv =====
// ---------------------------------------------------------------------------
// sxg_back
// Runs a generation command: one mix step and word per cycle unless stalled.
// ---------------------------------------------------------------------------
module sxg_back (
  input  logic                          clk,
  input  logic                          rst,
  input  sxg_pkg::gen_cmd_t             head_cmd,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sxg_pkg::STATE_W-1:0]   out_word,
  output logic [sxg_pkg::CNT_W-1:0]     byte_count,
  output logic                          last
);

  localparam logic [sxg_pkg::LEN_W-1:0] WORD_BYTES = sxg_pkg::LEN_W'(8);

  logic                        busy;
  logic [sxg_pkg::STATE_W-1:0] gen_state;
  logic [sxg_pkg::STATE_W-1:0] gen_const;
  logic [sxg_pkg::LEN_W-1:0]   remaining;

  logic                        step;
  logic                        final_word;
  logic [sxg_pkg::STATE_W-1:0] mixed;

  assign pop        = !busy && !empty;
  assign step       = busy && (!out_valid || out_ready);
  assign final_word = (remaining <= WORD_BYTES);
  assign mixed      = sxg_pkg::mix_step(gen_state, gen_const);

  always_ff @(posedge clk) begin
    if (pop) begin
      gen_state <= head_cmd.start_state;
      gen_const <= head_cmd.mix_const;
      remaining <= head_cmd.length;
    end else if (step) begin
      gen_state <= mixed;
      remaining <= final_word ? '0 : remaining - WORD_BYTES;
    end
    if (step) begin
      out_word   <= mixed;
      byte_count <= final_word ? sxg_pkg::CNT_W'(remaining) : sxg_pkg::CNT_W'(8);
      last       <= final_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (step && final_word) begin
        busy <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/salted_xorshift_byte_generator_unit.sv =====
// ---------------------------------------------------------------------------
// salted_xorshift_byte_generator_unit
// Salted xorshift64 byte generator with salt absorption and token/key output.
// ---------------------------------------------------------------------------
// A salt byte (op 0) is absorbed in the cycle it is accepted, one per cycle
// while the queue is not full. A token or key request is accepted, queued
// and popped by the back end once idle, which then produces one 8-byte word
// per cycle unless out_ready stalls it, ceil(length/8) words, the final one
// flagged by last, possibly partial; one mix step per word sets the rate. The
// command queue holds two requests; while it is full no item is accepted,
// so salt for a following request waits until a slot frees. Lengths above
// MAX_OUT_BYTES (and above 256) are clamped; zero length gives no output.
// Configuration writes take effect at once and belong to idle periods.
module salted_xorshift_byte_generator_unit #(
  parameter int unsigned MAX_OUT_BYTES = sxg_pkg::MAX_OUT_BYTES_D
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [sxg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sxg_pkg::STATE_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     op,
  input  logic [7:0]                     salt_byte,
  input  logic [sxg_pkg::LEN_W-1:0]      out_length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sxg_pkg::STATE_W-1:0]    out_word,
  output logic [sxg_pkg::CNT_W-1:0]      byte_count,
  output logic                           last
);

  logic              cmd_push;
  sxg_pkg::gen_cmd_t cmd;
  logic              cmd_full;
  logic              cmd_pop;
  sxg_pkg::gen_cmd_t head_cmd;
  logic              cmd_empty;

  sxg_front #(
    .MAX_OUT_BYTES(MAX_OUT_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .salt_byte  (salt_byte),
    .out_length (out_length),
    .cmd_push   (cmd_push),
    .cmd        (cmd),
    .cmd_full   (cmd_full)
  );

  sxg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .head_cmd (head_cmd),
    .empty    (cmd_empty)
  );

  sxg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_cmd   (head_cmd),
    .empty      (cmd_empty),
    .pop        (cmd_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .byte_count (byte_count),
    .last       (last)
  );

endmodule
